[sv/plen_pkg.sv]
// Shared widths, operation codes and status codes for the positional list engine.
package plen_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int MODE_W       = 3;
	localparam int POS_W        = 6;
	localparam int DATA_W       = 32;
	localparam int STATUS_W     = 2;
	localparam int LEN_W        = 7;

	typedef logic [MODE_W-1:0]   mode_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam mode_t MODE_APPEND    = 3'd0;
	localparam mode_t MODE_INSERT    = 3'd1;
	localparam mode_t MODE_DELETE    = 3'd2;
	localparam mode_t MODE_GET       = 3'd3;
	localparam mode_t MODE_GET_RANGE = 3'd4;
	localparam mode_t MODE_DEL_RANGE = 3'd5;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_RANGE = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

endpackage

[sv/positional_list_engine_unit.sv]
// Top level of the positional list engine: sequencer plus element store.
// Append, insert at the end and rejected operations answer from the decode state; get reads
// the store first; inner inserts shift elements up, then write; deletes shift the tail down.
// Get range streams one result per cycle, one per element in the window.
// The next start transfer can coincide with the final result; the receiver cannot stall.
// Reset clears the element count and sequencer; store contents stay undefined until written.
module positional_list_engine_unit import plen_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [MODE_W-1:0]        mode,
	input  logic [POS_W-1:0]         position,
	input  logic [POS_W-1:0]         end_position,
	input  logic signed [DATA_W-1:0] value,
	output logic                     valid,
	output logic signed [DATA_W-1:0] data,
	output logic [STATUS_W-1:0]      status,
	output logic [LEN_W-1:0]         length,
	output logic                     last
);

	localparam int AW = $clog2(CAPACITY);

	logic                     mem_we;
	logic [AW-1:0]            mem_waddr;
	logic signed [DATA_W-1:0] mem_wdata;
	logic [AW-1:0]            mem_raddr;
	logic signed [DATA_W-1:0] mem_rdata;

	plen_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.position     (position),
		.end_position (end_position),
		.value        (value),
		.valid        (valid),
		.data         (data),
		.status       (status),
		.length       (length),
		.last         (last),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	plen_store #(
		.CAPACITY (CAPACITY),
		.AW       (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

[sv/plen_store.sv]
// Element store: one write port and one registered read port.
module plen_store import plen_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int AW       = $clog2(CAPACITY)
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic signed [DATA_W-1:0] wdata,
	input  logic [AW-1:0]            raddr,
	output logic signed [DATA_W-1:0] rdata
);

	logic signed [DATA_W-1:0] mem_q [CAPACITY];
	logic signed [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/plen_ctrl.sv]
// Sequencer: decodes an operation and walks the store one element per cycle.
module plen_ctrl import plen_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int AW       = $clog2(CAPACITY)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [MODE_W-1:0]        mode,
	input  logic [POS_W-1:0]         position,
	input  logic [POS_W-1:0]         end_position,
	input  logic signed [DATA_W-1:0] value,
	output logic                     valid,
	output logic signed [DATA_W-1:0] data,
	output logic [STATUS_W-1:0]      status,
	output logic [LEN_W-1:0]         length,
	output logic                     last,
	output logic                     mem_we,
	output logic [AW-1:0]            mem_waddr,
	output logic signed [DATA_W-1:0] mem_wdata,
	output logic [AW-1:0]            mem_raddr,
	input  logic signed [DATA_W-1:0] mem_rdata
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_UP,
		S_PUT,
		S_DOWN,
		S_READ
	} state_t;

	state_t                   state_q;
	mode_t                    mode_q;
	logic [IW-1:0]            pos_q;
	logic [IW-1:0]            endp_q;
	logic [IW-1:0]            rd_q;
	logic [IW-1:0]            dst_q;
	logic [IW-1:0]            hi_q;
	logic signed [DATA_W-1:0] val_q;
	logic [CW-1:0]            count_q;
	logic                     valid_q;
	logic signed [DATA_W-1:0] data_q;
	status_t                  status_q;
	logic                     last_q;

	logic [IW-1:0] cnt_x;
	logic [IW-1:0] hi_clip;
	logic [IW-1:0] hi_eff;
	logic          full;
	logic          is_range;
	logic          win_bad;

	assign cnt_x    = IW'(count_q);
	assign full     = (count_q == CW'(CAPACITY));
	assign hi_clip  = (endp_q < cnt_x) ? endp_q : IW'(cnt_x - 1'b1);
	assign is_range = (mode_q == MODE_GET_RANGE) || (mode_q == MODE_DEL_RANGE);
	assign hi_eff   = is_range ? hi_clip : pos_q;
	assign win_bad  = (pos_q >= cnt_x) || (is_range && (pos_q > endp_q));

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(rd_q + 1'b1);
		mem_wdata = mem_rdata;
		mem_raddr = AW'(rd_q + 1'b1);
		case (state_q)
			S_DECODE: begin
				case (mode_q)
					MODE_APPEND: begin
						mem_we    = !full;
						mem_waddr = AW'(cnt_x);
						mem_wdata = val_q;
					end
					MODE_INSERT: begin
						mem_we    = (pos_q == cnt_x) && !full;
						mem_waddr = AW'(pos_q);
						mem_wdata = val_q;
						mem_raddr = AW'(cnt_x - 1'b1);
					end
					MODE_DELETE, MODE_DEL_RANGE: begin
						mem_raddr = AW'(hi_eff + 1'b1);
					end
					default: begin
						mem_raddr = AW'(pos_q);
					end
				endcase
			end
			S_UP: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(rd_q + 1'b1);
				mem_raddr = AW'(rd_q - 1'b1);
			end
			S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(pos_q);
				mem_wdata = val_q;
			end
			S_DOWN: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(dst_q);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mode_q   <= MODE_APPEND;
			pos_q    <= '0;
			endp_q   <= '0;
			rd_q     <= '0;
			dst_q    <= '0;
			hi_q     <= '0;
			val_q    <= '0;
			count_q  <= '0;
			valid_q  <= 1'b0;
			data_q   <= '0;
			status_q <= ST_OK;
			last_q   <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			data_q  <= '0;
			last_q  <= 1'b1;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						mode_q  <= mode;
						pos_q   <= IW'(position);
						endp_q  <= IW'(end_position);
						val_q   <= value;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					state_q  <= S_IDLE;
					status_q <= ST_RANGE;
					valid_q  <= 1'b1;
					case (mode_q)
						MODE_APPEND: begin
							if (full) begin
								status_q <= ST_FULL;
							end else begin
								status_q <= ST_OK;
								count_q  <= CW'(count_q + 1'b1);
							end
						end
						MODE_INSERT: begin
							if (pos_q > cnt_x) begin
								status_q <= ST_RANGE;
							end else if (full) begin
								status_q <= ST_FULL;
							end else if (pos_q == cnt_x) begin
								status_q <= ST_OK;
								count_q  <= CW'(count_q + 1'b1);
							end else begin
								valid_q <= 1'b0;
								rd_q    <= IW'(cnt_x - 1'b1);
								state_q <= S_UP;
							end
						end
						MODE_DELETE, MODE_DEL_RANGE: begin
							if (!win_bad) begin
								if (IW'(hi_eff + 1'b1) == cnt_x) begin
									status_q <= ST_OK;
									count_q  <= CW'(pos_q);
								end else begin
									valid_q <= 1'b0;
									rd_q    <= IW'(hi_eff + 1'b1);
									dst_q   <= pos_q;
									state_q <= S_DOWN;
								end
							end
						end
						MODE_GET, MODE_GET_RANGE: begin
							if (!win_bad) begin
								valid_q <= 1'b0;
								rd_q    <= pos_q;
								hi_q    <= hi_eff;
								state_q <= S_READ;
							end
						end
						default: begin
							status_q <= ST_RANGE;
						end
					endcase
				end
				S_UP: begin
					if (rd_q == pos_q) begin
						state_q <= S_PUT;
					end else begin
						rd_q <= IW'(rd_q - 1'b1);
					end
				end
				S_PUT: begin
					count_q  <= CW'(count_q + 1'b1);
					status_q <= ST_OK;
					valid_q  <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_DOWN: begin
					if (rd_q == IW'(cnt_x - 1'b1)) begin
						count_q  <= CW'(dst_q + 1'b1);
						status_q <= ST_OK;
						valid_q  <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						rd_q  <= IW'(rd_q + 1'b1);
						dst_q <= IW'(dst_q + 1'b1);
					end
				end
				S_READ: begin
					valid_q  <= 1'b1;
					data_q   <= mem_rdata;
					status_q <= ST_OK;
					last_q   <= (rd_q == hi_q);
					if (rd_q == hi_q) begin
						state_q <= S_IDLE;
					end else begin
						rd_q <= IW'(rd_q + 1'b1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign valid  = valid_q;
	assign data   = data_q;
	assign status = status_q;
	assign length = LEN_W'(count_q);
	assign last   = last_q;

endmodule

[test/tb_top.sv]
// Self-checking testbench for the positional list engine: directed and random list operations.
`timescale 1ns / 100ps
module tb_top;
	import plen_pkg::*;

	localparam mode_t MODE_SPARE_A = 3'd6;
	localparam mode_t MODE_SPARE_B = 3'd7;
	localparam int    RANDOM_OPS   = 300;

	typedef struct {
		mode_t                    mode;
		logic [POS_W-1:0]         position;
		logic [POS_W-1:0]         end_position;
		logic signed [DATA_W-1:0] value;
	} list_op_t;

	typedef struct {
		logic signed [DATA_W-1:0] data;
		status_t                  status;
		logic [LEN_W-1:0]         length;
		logic                     last;
	} list_result_t;

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     start        = 1'b0;
	mode_t                    mode         = MODE_APPEND;
	logic [POS_W-1:0]         position     = '0;
	logic [POS_W-1:0]         end_position = '0;
	logic signed [DATA_W-1:0] value        = '0;
	logic                     busy;
	logic                     valid;
	logic signed [DATA_W-1:0] data;
	logic [STATUS_W-1:0]      status;
	logic [LEN_W-1:0]         length;
	logic                     last;

	list_op_t                 pending_ops[$];
	list_result_t             expected_results[$];
	logic signed [DATA_W-1:0] list_model[$];
	int                       mismatch_count = 0;
	int                       burst_left     = 1;
	int                       gap_left       = 0;

	positional_list_engine_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.position     (position),
		.end_position (end_position),
		.value        (value),
		.valid        (valid),
		.data         (data),
		.status       (status),
		.length       (length),
		.last         (last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic add_list_result(logic signed [DATA_W-1:0] d, status_t st, logic lst);
		list_result_t r;
		r.data   = d;
		r.status = st;
		r.length = LEN_W'(list_model.size());
		r.last   = lst;
		expected_results.push_back(r);
	endtask

	task automatic apply_list_op(list_op_t op);
		int cnt;
		int pos;
		int hi;
		cnt = list_model.size();
		pos = int'(op.position);
		case (op.mode)
			MODE_APPEND: begin
				if (cnt >= CAPACITY_DEF) begin
					add_list_result('0, ST_FULL, 1'b1);
				end else begin
					list_model.push_back(op.value);
					add_list_result('0, ST_OK, 1'b1);
				end
			end
			MODE_INSERT: begin
				if (pos > cnt) begin
					add_list_result('0, ST_RANGE, 1'b1);
				end else if (cnt >= CAPACITY_DEF) begin
					add_list_result('0, ST_FULL, 1'b1);
				end else begin
					list_model.insert(pos, op.value);
					add_list_result('0, ST_OK, 1'b1);
				end
			end
			MODE_DELETE: begin
				if (pos >= cnt) begin
					add_list_result('0, ST_RANGE, 1'b1);
				end else begin
					list_model.delete(pos);
					add_list_result('0, ST_OK, 1'b1);
				end
			end
			MODE_GET: begin
				if (pos >= cnt)
					add_list_result('0, ST_RANGE, 1'b1);
				else
					add_list_result(list_model[pos], ST_OK, 1'b1);
			end
			MODE_GET_RANGE, MODE_DEL_RANGE: begin
				if (pos > int'(op.end_position) || pos >= cnt) begin
					add_list_result('0, ST_RANGE, 1'b1);
				end else begin
					hi = int'(op.end_position);
					if (hi > cnt - 1)
						hi = cnt - 1;
					if (op.mode == MODE_GET_RANGE) begin
						for (int i = pos; i <= hi; i++)
							add_list_result(list_model[i], ST_OK, i == hi);
					end else begin
						for (int i = pos; i <= hi; i++)
							list_model.delete(pos);
						add_list_result('0, ST_OK, 1'b1);
					end
				end
			end
			default: add_list_result('0, ST_RANGE, 1'b1);
		endcase
	endtask

	task automatic queue_op(mode_t m, int p, int e, logic [DATA_W-1:0] v);
		list_op_t op;
		op.mode         = m;
		op.position     = POS_W'(p);
		op.end_position = POS_W'(e);
		op.value        = v;
		pending_ops.push_back(op);
	endtask

	function automatic list_op_t random_list_op(int cnt, bit grow);
		list_op_t op;
		int       pick;
		int       e;
		pick = $urandom_range(0, 99);
		if (grow)
			op.mode = pick < 55 ? MODE_APPEND : pick < 80 ? MODE_INSERT :
				pick < 88 ? MODE_GET : pick < 94 ? MODE_GET_RANGE :
				pick < 97 ? MODE_DELETE : pick < 98 ? MODE_DEL_RANGE :
				pick < 99 ? MODE_SPARE_A : MODE_SPARE_B;
		else
			op.mode = pick < 25 ? MODE_DELETE : pick < 45 ? MODE_DEL_RANGE :
				pick < 60 ? MODE_GET : pick < 75 ? MODE_GET_RANGE :
				pick < 85 ? MODE_APPEND : pick < 95 ? MODE_INSERT :
				pick < 97 ? MODE_SPARE_A : MODE_SPARE_B;
		if (cnt == 0 || $urandom_range(0, 9) == 0)
			op.position = POS_W'($urandom_range(0, 63));
		else if (op.mode == MODE_INSERT)
			op.position = POS_W'($urandom_range(0, cnt > 63 ? 63 : cnt));
		else
			op.position = POS_W'($urandom_range(0, cnt - 1));
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			e = int'(op.position) + int'($urandom_range(0, 5));
			op.end_position = POS_W'(e > 63 ? 63 : e);
		end else if (pick < 8) begin
			op.end_position = POS_W'($urandom_range(0, 63));
		end else begin
			op.end_position = POS_W'(63);
		end
		pick = $urandom_range(0, 9);
		op.value = pick == 0 ? 32'h8000_0000 : pick == 1 ? 32'h7FFF_FFFF : $urandom;
		return op;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic     accepted;
		list_op_t op;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			accepted = start && !busy;
			if (accepted) begin
				op = pending_ops.pop_front();
				apply_list_op(op);
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end
			end
			if (start && !accepted) begin
				// hold the item until the transfer
			end else if (gap_left > 0 || pending_ops.size() == 0) begin
				start <= 1'b0;
				if (gap_left > 0)
					gap_left--;
			end else begin
				start        <= 1'b1;
				mode         <= pending_ops[0].mode;
				position     <= pending_ops[0].position;
				end_position <= pending_ops[0].end_position;
				value        <= pending_ops[0].value;
			end
		end
	end

	always @(posedge clk) begin
		list_result_t exp_r;
		if (arst_n && valid) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result data=%0d status=%0d length=%0d",
					data, status, length));
			end else begin
				exp_r = expected_results.pop_front();
				if (data !== exp_r.data)
					report_mismatch($sformatf("data %0d, want %0d", data, exp_r.data));
				if (status !== exp_r.status)
					report_mismatch($sformatf("status %0d, want %0d", status, exp_r.status));
				if (length !== exp_r.length)
					report_mismatch($sformatf("length %0d, want %0d", length, exp_r.length));
				if (last !== exp_r.last)
					report_mismatch($sformatf("last %0b, want %0b", last, exp_r.last));
			end
		end
	end

	initial begin
		int cnt;
		bit grow;
		int target;
		queue_op(MODE_GET,       0,  0,  32'h0);
		queue_op(MODE_DELETE,    0,  0,  32'h0);
		queue_op(MODE_GET_RANGE, 0,  63, 32'h0);
		queue_op(MODE_DEL_RANGE, 0,  0,  32'h0);
		queue_op(MODE_INSERT,    1,  0,  32'h1234_5678);
		queue_op(MODE_INSERT,    0,  0,  32'h8000_0000);
		queue_op(MODE_APPEND,    63, 63, 32'h7FFF_FFFF);
		queue_op(MODE_APPEND,    0,  0,  32'hFFFF_FFFF);
		queue_op(MODE_INSERT,    3,  0,  32'h0);
		queue_op(MODE_INSERT,    1,  0,  32'h5555_5555);
		queue_op(MODE_GET,       4,  0,  32'h0);
		queue_op(MODE_GET,       5,  0,  32'h0);
		queue_op(MODE_GET,       63, 0,  32'h0);
		queue_op(MODE_GET_RANGE, 3,  1,  32'h0);
		queue_op(MODE_GET_RANGE, 1,  63, 32'h0);
		queue_op(MODE_GET_RANGE, 2,  2,  32'h0);
		queue_op(MODE_GET_RANGE, 5,  63, 32'h0);
		queue_op(MODE_SPARE_A,   63, 63, 32'hFFFF_FFFF);
		queue_op(MODE_SPARE_B,   0,  0,  32'h0);
		queue_op(MODE_DELETE,    0,  0,  32'h0);
		queue_op(MODE_DELETE,    3,  0,  32'h0);
		queue_op(MODE_DEL_RANGE, 1,  1,  32'h0);
		queue_op(MODE_DEL_RANGE, 4,  2,  32'h0);
		queue_op(MODE_DEL_RANGE, 0,  63, 32'h0);

		grow = 1'b1;
		target = CAPACITY_DEF;
		for (int n = 0; n < RANDOM_OPS; n++) begin
			while (pending_ops.size() > 1)
				@(negedge clk);
			cnt = list_model.size();
			if (grow && cnt >= target && $urandom_range(0, 3) == 0) begin
				grow = 1'b0;
				target = $urandom_range(0, 16);
			end else if (!grow && cnt <= target) begin
				grow = 1'b1;
				target = $urandom_range(0, 1) ? CAPACITY_DEF : $urandom_range(8, CAPACITY_DEF);
			end
			pending_ops.push_back(random_list_op(cnt, grow));
		end

		while (pending_ops.size() != 0 || start || expected_results.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

[filelist.f]
sv/plen_pkg.sv
sv/plen_store.sv
sv/plen_ctrl.sv
sv/positional_list_engine_unit.sv
test/tb_top.sv
